/* rtl/core/owm_pkg.sv */
`timescale 1ns / 1ps
package owm_pkg;

   // request kinds
   localparam logic [2:0] KIND_TICK  = 3'd0;
   localparam logic [2:0] KIND_RESET = 3'd1;
   localparam logic [2:0] KIND_WBYTE = 3'd2;
   localparam logic [2:0] KIND_RBYTE = 3'd3;
   localparam logic [2:0] KIND_WBIT  = 3'd4;
   localparam logic [2:0] KIND_RBIT  = 3'd5;

   // line drive codes
   localparam logic [1:0] DRV_REL  = 2'd0;
   localparam logic [1:0] DRV_LOW  = 2'd1;
   localparam logic [1:0] DRV_HIGH = 2'd2;

   // slot timing in 1 us ticks
   localparam logic [8:0] T_RST_LOW  = 9'd480;
   localparam logic [8:0] T_RST_SAMP = 9'd70;
   localparam logic [8:0] T_RST_WAIT = 9'd410;
   localparam logic [8:0] T_WR1_LOW  = 9'd10;
   localparam logic [8:0] T_WR1_HIGH = 9'd55;
   localparam logic [8:0] T_WR0_LOW  = 9'd65;
   localparam logic [8:0] T_WR0_HIGH = 9'd5;
   localparam logic [8:0] T_RD_LOW   = 9'd3;
   localparam logic [8:0] T_RD_SAMP  = 9'd10;
   localparam logic [8:0] T_RD_WAIT  = 9'd53;

   typedef enum logic [1:0] {
      CLS_TICK,
      CLS_CMD,
      CLS_NOP
   } item_cls_type;

   typedef struct packed {
      item_cls_type cls;
      logic [2:0]   kind;
      logic [7:0]   load_data;  // shift register value for a command
      logic         line_level;
   } item_type;

endpackage

/* rtl/core/owm_front.sv */
`timescale 1ns / 1ps
module owm_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [2:0]        req_kind,
   input  logic [7:0]        req_data,
   input  logic              req_line_level,
   output logic              q_valid,
   input  logic              q_ready,
   output owm_pkg::item_type q_item
);
   import owm_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   item_type   item_in;
   logic       push;
   logic       pop;

   always_comb begin
      item_in            = '0;
      item_in.kind       = req_kind;
      item_in.line_level = req_line_level;
      case (req_kind) inside
         KIND_TICK:              item_in.cls = CLS_TICK;
         [KIND_RESET:KIND_RBIT]: item_in.cls = CLS_CMD;
         default:                item_in.cls = CLS_NOP;
      endcase
      case (req_kind)
         KIND_WBYTE: item_in.load_data = req_data;
         KIND_WBIT:  item_in.load_data = {7'd0, req_data[0]};
         default:    item_in.load_data = 8'd0;
      endcase
   end

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign pop       = q_valid && q_ready;
   assign q_item    = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            slot_ff[wr_ptr_ff] <= item_in;
            wr_ptr_ff          <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule

/* rtl/core/owm_back.sv */
`timescale 1ns / 1ps
module owm_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_ready,
   input  owm_pkg::item_type q_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_line_drive,
   output logic              rsp_busy_res,
   output logic              rsp_done_res,
   output logic [7:0]        rsp_read_value,
   output logic              rsp_presence,
   output logic              rsp_rejected
);
   import owm_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_RLOW,
      PH_RSAMP,
      PH_RWAIT,
      PH_WLOW,
      PH_WHIGH,
      PH_DLOW,
      PH_DSAMP,
      PH_DWAIT
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [2:0] operation_ff, operation_in;
   logic [8:0] tick_ff, tick_in;
   logic [2:0] bit_index_ff, bit_index_in;
   logic [7:0] shift_ff, shift_in;
   logic       presence_ff, presence_in;
   logic [1:0] drive_ff, drive_in;
   logic [7:0] read_hold_ff, read_hold_in;
   logic       done_in;
   logic       rej_in;
   logic       rsp_valid_ff;
   logic [1:0] rsp_drive_ff;
   logic       rsp_busy_ff;
   logic       rsp_done_ff;
   logic [7:0] rsp_read_ff;
   logic       rsp_presence_ff;
   logic       rsp_rej_ff;
   logic       pop;
   logic [8:0] tick_inc;
   logic       cur_bit;

   assign q_ready  = !rsp_valid_ff || rsp_ready;
   assign pop      = q_valid && q_ready;
   assign tick_inc = tick_ff + 9'd1;
   assign cur_bit  = shift_ff[bit_index_ff];

   always_comb begin
      phase_in     = phase_ff;
      operation_in = operation_ff;
      tick_in      = tick_ff;
      bit_index_in = bit_index_ff;
      shift_in     = shift_ff;
      presence_in  = presence_ff;
      drive_in     = drive_ff;
      read_hold_in = read_hold_ff;
      done_in      = 1'b0;
      rej_in       = 1'b0;
      case (q_item.cls)
         CLS_TICK: begin
            if (phase_ff != PH_IDLE) begin
               tick_in = tick_inc;
               case (phase_ff)
                  PH_RLOW: begin
                     if (tick_inc >= T_RST_LOW) begin
                        phase_in = PH_RSAMP;
                        drive_in = DRV_REL;
                        tick_in  = 9'd0;
                     end
                  end
                  PH_RSAMP: begin
                     if (tick_inc >= T_RST_SAMP) begin
                        presence_in = !q_item.line_level;
                        phase_in    = PH_RWAIT;
                        drive_in    = DRV_REL;
                        tick_in     = 9'd0;
                     end
                  end
                  PH_RWAIT: begin
                     if (tick_inc >= T_RST_WAIT) begin
                        done_in = 1'b1;
                     end
                  end
                  PH_WLOW: begin
                     if (tick_inc >= (cur_bit ? T_WR1_LOW : T_WR0_LOW)) begin
                        phase_in = PH_WHIGH;
                        drive_in = DRV_HIGH;
                        tick_in  = 9'd0;
                     end
                  end
                  PH_WHIGH: begin
                     if (tick_inc >= (cur_bit ? T_WR1_HIGH : T_WR0_HIGH)) begin
                        if (operation_ff == KIND_WBYTE && bit_index_ff != 3'd7) begin
                           bit_index_in = bit_index_ff + 3'd1;
                           phase_in     = PH_WLOW;
                           drive_in     = DRV_LOW;
                           tick_in      = 9'd0;
                        end else begin
                           done_in = 1'b1;
                        end
                     end
                  end
                  PH_DLOW: begin
                     if (tick_inc >= T_RD_LOW) begin
                        phase_in = PH_DSAMP;
                        drive_in = DRV_REL;
                        tick_in  = 9'd0;
                     end
                  end
                  PH_DSAMP: begin
                     if (tick_inc >= T_RD_SAMP) begin
                        if (q_item.line_level) begin
                           shift_in[bit_index_ff] = 1'b1;
                        end
                        phase_in = PH_DWAIT;
                        drive_in = DRV_REL;
                        tick_in  = 9'd0;
                     end
                  end
                  PH_DWAIT: begin
                     if (tick_inc >= T_RD_WAIT) begin
                        if (operation_ff == KIND_RBYTE && bit_index_ff != 3'd7) begin
                           bit_index_in = bit_index_ff + 3'd1;
                           phase_in     = PH_DLOW;
                           drive_in     = DRV_LOW;
                           tick_in      = 9'd0;
                        end else begin
                           read_hold_in = shift_ff;
                           done_in      = 1'b1;
                        end
                     end
                  end
                  default: begin
                     phase_in = PH_IDLE;
                     drive_in = DRV_REL;
                     tick_in  = 9'd0;
                  end
               endcase
               if (done_in) begin
                  phase_in = PH_IDLE;
                  drive_in = DRV_REL;
                  tick_in  = 9'd0;
               end
            end
         end
         CLS_CMD: begin
            if (phase_ff != PH_IDLE) begin
               rej_in = 1'b1;
            end else begin
               operation_in = q_item.kind;
               bit_index_in = 3'd0;
               shift_in     = q_item.load_data;
               drive_in     = DRV_LOW;
               tick_in      = 9'd0;
               case (q_item.kind)
                  KIND_RESET:            phase_in = PH_RLOW;
                  KIND_WBYTE, KIND_WBIT: phase_in = PH_WLOW;
                  default:               phase_in = PH_DLOW;
               endcase
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         operation_ff <= 3'd0;
         tick_ff      <= 9'd0;
         bit_index_ff <= 3'd0;
         shift_ff     <= 8'd0;
         presence_ff  <= 1'b0;
         drive_ff     <= DRV_REL;
         read_hold_ff <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else if (pop) begin
         phase_ff        <= phase_in;
         operation_ff    <= operation_in;
         tick_ff         <= tick_in;
         bit_index_ff    <= bit_index_in;
         shift_ff        <= shift_in;
         presence_ff     <= presence_in;
         drive_ff        <= drive_in;
         read_hold_ff    <= read_hold_in;
         rsp_valid_ff    <= 1'b1;
         rsp_drive_ff    <= drive_in;
         rsp_busy_ff     <= (phase_in != PH_IDLE);
         rsp_done_ff     <= done_in;
         rsp_read_ff     <= read_hold_in;
         rsp_presence_ff <= presence_in;
         rsp_rej_ff      <= rej_in;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_line_drive = rsp_drive_ff;
   assign rsp_busy_res   = rsp_busy_ff;
   assign rsp_done_res   = rsp_done_ff;
   assign rsp_read_value = rsp_read_ff;
   assign rsp_presence   = rsp_presence_ff;
   assign rsp_rejected   = rsp_rej_ff;

endmodule

/* rtl/core/onewire_bus_master_top.sv */
`timescale 1ns / 1ps
// One-wire bus master stepped by request items: a tick request advances the running
// operation by one microsecond (sampling req_line_level), a command request starts a
// reset, byte/bit write or byte/bit read when idle and is flagged rejected when busy.
// Every request yields exactly one response with the line drive to apply and status.
// Throughput is one request per clock while rsp_ready is high; a request passes
// through the two-entry request queue, then the slot sequencer's response register.
// The sequencer's state update is the only loop, so there is no wait between requests.
module onewire_bus_master_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_kind,
   input  logic [7:0] req_data,
   input  logic       req_line_level,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_line_drive,
   output logic       rsp_busy_res,
   output logic       rsp_done_res,
   output logic [7:0] rsp_read_value,
   output logic       rsp_presence,
   output logic       rsp_rejected
);
   import owm_pkg::*;

   logic     q_valid;
   logic     q_ready;
   item_type q_item;

   owm_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_data       (req_data),
      .req_line_level (req_line_level),
      .q_valid        (q_valid),
      .q_ready        (q_ready),
      .q_item         (q_item)
   );

   owm_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_ready        (q_ready),
      .q_item         (q_item),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_line_drive (rsp_line_drive),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_done_res   (rsp_done_res),
      .rsp_read_value (rsp_read_value),
      .rsp_presence   (rsp_presence),
      .rsp_rejected   (rsp_rejected)
   );

endmodule
